FILE: rtl/overlapping_sta_lta_ratio_macros.svh
// Assertion macros shared by the STA/LTA ratio block.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef OVERLAPPING_STA_LTA_RATIO_MACROS_SVH
`define OVERLAPPING_STA_LTA_RATIO_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define STALTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STALTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/stalta_pkg.sv
`timescale 1ns / 1ps

package stalta_pkg;

  localparam int DEF_MAX_LONG_WINDOW = 4096;
  localparam int DEF_SAMPLE_BITS     = 32;

  // Quotient bits of the Q16.16 ratio and the fraction shift.
  localparam int QUOT_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int STA_W = 12;
  localparam int LTA_W = 13;
  localparam logic [STA_W-1:0] STA_RESET = 12'd64;
  localparam logic [LTA_W-1:0] LTA_RESET = 13'd1024;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STA_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LTA_LENGTH = 2'd1;

  typedef struct packed {
    logic [31:0] sample;
    logic        last_sample;
  } item_t;

  typedef struct packed {
    logic [31:0] ratio;
    logic        ratio_valid;
    logic        zero_long_sum;
    logic        trace_end;
  } result_t;

  typedef struct packed {
    logic take_in;    // capture the accepted item
    logic add_in;     // add the new sample to both sums
    logic rd_en;      // read the history memory
    logic rd_long;    // read address is the long-window tap
    logic cap_short;  // hold the short-window tap value
    logic upd;        // retire old samples, write history, advance pointers
    logic mul;        // form numerator and denominator products
    logic load_div;   // load the divider, end the trace if flagged
    logic div_step;   // one quotient bit
    logic load_out;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/stalta_ctrl.sv
`timescale 1ns / 1ps

module stalta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  stalta_pkg::stat_t stat,
  output stalta_pkg::cmd_t  cmd
);
  import stalta_pkg::*;

  localparam int CNT_W = $clog2(QUOT_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_RDS, S_RDL, S_UPD, S_MUL, S_LOAD, S_DIV, S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take_in   = (state == S_IDLE) && item_valid;
    cmd.add_in    = (state == S_RDS);
    cmd.rd_en     = (state == S_RDS) || (state == S_RDL);
    cmd.rd_long   = (state == S_RDL);
    cmd.cap_short = (state == S_RDL);
    cmd.upd       = (state == S_UPD);
    cmd.mul       = (state == S_MUL);
    cmd.load_div  = (state == S_LOAD);
    cmd.div_step  = (state == S_DIV);
    cmd.load_out  = (state == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_RDS;
        end
        S_RDS:  state <= S_RDL;
        S_RDL:  state <= S_UPD;
        S_UPD:  state <= S_MUL;
        S_MUL:  state <= S_LOAD;
        S_LOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QUOT_BITS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/stalta_dp.sv
`timescale 1ns / 1ps
`include "overlapping_sta_lta_ratio_macros.svh"

module stalta_dp #(
  parameter int MAX_LONG_WINDOW = stalta_pkg::DEF_MAX_LONG_WINDOW,
  parameter int SAMPLE_BITS     = stalta_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  stalta_pkg::cmd_t                   cmd,
  output stalta_pkg::stat_t                  stat,
  input  stalta_pkg::item_t                  item,
  input  logic                               cfg_valid,
  input  logic [stalta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                        cfg_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output stalta_pkg::result_t                result
);
  import stalta_pkg::*;

  localparam int XW  = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int AW  = $clog2(MAX_LONG_WINDOW);
  localparam int NLW = $clog2(MAX_LONG_WINDOW + 1);
  localparam int CW  = (NLW > LTA_W) ? NLW : LTA_W;
  localparam int SW  = XW + NLW;
  localparam int PW  = SW + NLW;
  localparam int NW  = PW + FRAC_BITS;
  localparam int RW  = PW + 1;
  localparam int EW  = NLW + 1;

  // Configuration
  logic [STA_W-1:0] sta_length;
  logic [LTA_W-1:0] lta_length;
  logic [CW-1:0]    lta_c, sta_c, nl_c, ns_c;
  logic [NLW-1:0]   nl, ns;

  always_comb begin
    lta_c = CW'(lta_length);
    sta_c = CW'(sta_length);
    if (lta_c > CW'(MAX_LONG_WINDOW)) nl_c = CW'(MAX_LONG_WINDOW);
    else if (lta_c < CW'(2))          nl_c = CW'(2);
    else                              nl_c = lta_c;
    if (sta_c == '0)      ns_c = CW'(1);
    else if (sta_c > nl_c) ns_c = nl_c;
    else                   ns_c = sta_c;
  end

  assign nl = NLW'(nl_c);
  assign ns = NLW'(ns_c);

  // Trace state
  logic [XW-1:0]  mem [MAX_LONG_WINDOW];
  logic [XW-1:0]  x, rdata, old_s;
  logic           last_r;
  logic [AW-1:0]  wp, rd_addr;
  logic [NLW-1:0] seen, seen_next;
  logic [SW-1:0]  short_sum, long_sum;
  logic [EW-1:0]  wp_e, len_e, addr_e;
  logic           valid_r, zero_r;

  always_comb begin
    wp_e  = EW'(wp);
    len_e = cmd.rd_long ? EW'(nl) : EW'(ns);
    if (wp_e >= len_e) addr_e = wp_e - len_e;
    else               addr_e = wp_e + EW'(MAX_LONG_WINDOW) - len_e;
  end

  assign rd_addr   = AW'(addr_e);
  assign seen_next = (seen < nl) ? seen + 1'b1 : nl;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= mem[rd_addr];
    if (cmd.upd)   mem[wp] <= x;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x      <= item.sample[XW-1:0];
      last_r <= item.last_sample;
    end
    if (cmd.cap_short) old_s <= rdata;
  end

  logic cfg_hit;
  assign cfg_hit = cfg_valid &&
                   ((cfg_index == CFG_STA_LENGTH) || (cfg_index == CFG_LTA_LENGTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      sta_length <= STA_RESET;
      lta_length <= LTA_RESET;
      short_sum  <= '0;
      long_sum   <= '0;
      seen       <= '0;
      wp         <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == CFG_STA_LENGTH) sta_length <= cfg_data[STA_W-1:0];
      else                             lta_length <= cfg_data[LTA_W-1:0];
      short_sum <= '0;
      long_sum  <= '0;
      seen      <= '0;
      wp        <= '0;
    end else begin
      if (cmd.add_in) begin
        short_sum <= short_sum + SW'(x);
        long_sum  <= long_sum + SW'(x);
      end
      if (cmd.upd) begin
        // Samples that drop out of each window leave the sums.
        if (seen >= ns) short_sum <= short_sum - SW'(old_s);
        if (seen >= nl) long_sum  <= long_sum - SW'(rdata);
        wp   <= (wp == AW'(MAX_LONG_WINDOW - 1)) ? '0 : wp + 1'b1;
        seen <= seen_next;
      end
      if (cmd.load_div && last_r) begin
        short_sum <= '0;
        long_sum  <= '0;
        seen      <= '0;
        wp        <= '0;
      end
    end
  end

  // Ratio: short_sum * nl * 2^16 / (long_sum * ns)
  logic [PW-1:0]        prod_n, prod_d;
  logic [NW-1:0]        numer;
  logic [RW-1:0]        rem, rem_sh;
  logic [QUOT_BITS-1:0] lo_bits, quot;
  logic                 sat_r, ge;

  assign numer  = {prod_n, FRAC_BITS'(0)};
  assign rem_sh = {rem[RW-2:0], lo_bits[QUOT_BITS-1]};
  assign ge     = rem_sh >= RW'(prod_d);

  always_ff @(posedge clk) begin
    if (cmd.upd) valid_r <= (seen_next >= nl);
    if (cmd.mul) begin
      prod_n <= PW'(short_sum) * PW'(nl);
      prod_d <= PW'(long_sum) * PW'(ns);
      zero_r <= (long_sum == '0);
    end
    if (cmd.load_div) begin
      // The quotient overflows 32 bits exactly when the upper part reaches the divisor.
      rem     <= RW'(numer >> QUOT_BITS);
      lo_bits <= QUOT_BITS'(numer);
      sat_r   <= (RW'(numer >> QUOT_BITS) >= RW'(prod_d));
      quot    <= '0;
    end
    if (cmd.div_step) begin
      rem     <= ge ? rem_sh - RW'(prod_d) : rem_sh;
      lo_bits <= {lo_bits[QUOT_BITS-2:0], 1'b0};
      quot    <= {quot[QUOT_BITS-2:0], ge};
    end
  end

  // Output register
  assign stat.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (!valid_r || zero_r) result.ratio <= '0;
      else if (sat_r)         result.ratio <= '1;
      else                    result.ratio <= quot;
      result.ratio_valid   <= valid_r;
      result.zero_long_sum <= valid_r && zero_r;
      result.trace_end     <= last_r;
    end
  end

  `STALTA_ASSERT_IMP(a_seen_bound, 1'b1, seen <= nl, "sample count exceeds long window")
  `STALTA_ASSERT_IMP(a_sum_order, 1'b1, short_sum <= long_sum, "short sum above long sum")
  `STALTA_ASSERT_NXT(a_out_no_overwrite, result_valid && result_stall,
                     result_valid && $stable(result), "stalled result overwritten")

endmodule

FILE: rtl/overlapping_sta_lta_ratio.sv
`timescale 1ns / 1ps
// An item passes the short and long tap reads, window update, multiply,
// divider load, bit-serial Q16.16 divide and output state (held while the
// output stalls) before the block takes the next item.
// Reset (rst, synchronous): window lengths return to 64 and 1024, sums, sample
// count and write pointer clear; the history memory is not cleared.
module overlapping_sta_lta_ratio #(
  parameter int MAX_LONG_WINDOW = stalta_pkg::DEF_MAX_LONG_WINDOW,
  parameter int SAMPLE_BITS     = stalta_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  stalta_pkg::item_t                  item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output stalta_pkg::result_t                result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stalta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                        cfg_data
);
  import stalta_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Writes are taken on any cycle; the user must write only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  stalta_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  stalta_dp #(
    .MAX_LONG_WINDOW (MAX_LONG_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: tb/sv/overlapping_sta_lta_ratio_test.sv
`timescale 1ns / 1ps

// Tracks window sums and history for every accepted transaction and holds the
// ratios that the block owes, oldest first.
class ratio_scoreboard;
  localparam int WINDOW = stalta_pkg::DEF_MAX_LONG_WINDOW;

  logic [stalta_pkg::STA_W-1:0] sta_len;
  logic [stalta_pkg::LTA_W-1:0] lta_len;
  logic [31:0] history [WINDOW];
  logic [63:0] short_sum;
  logic [63:0] long_sum;
  int seen;
  int wptr;
  stalta_pkg::result_t expected_ratios [$];
  int failures;

  function new();
    sta_len = stalta_pkg::STA_RESET;
    lta_len = stalta_pkg::LTA_RESET;
    failures = 0;
    clear_trace();
  endfunction

  function void clear_trace();
    short_sum = '0;
    long_sum = '0;
    seen = 0;
    wptr = 0;
  endfunction

  function void set_register(logic [stalta_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    if (idx == stalta_pkg::CFG_STA_LENGTH) begin
      sta_len = data[stalta_pkg::STA_W-1:0];
      clear_trace();
    end else if (idx == stalta_pkg::CFG_LTA_LENGTH) begin
      lta_len = data[stalta_pkg::LTA_W-1:0];
      clear_trace();
    end
  endfunction

  function void take_sample(stalta_pkg::item_t it);
    int nl;
    int ns;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    stalta_pkg::result_t r;
    nl = int'(lta_len);
    if (nl < 2) nl = 2;
    if (nl > WINDOW) nl = WINDOW;
    ns = int'(sta_len);
    if (ns < 1) ns = 1;
    if (ns > nl) ns = nl;

    // Both taps are read before the new sample overwrites its slot.
    short_sum += 64'(it.sample);
    long_sum += 64'(it.sample);
    if (seen >= ns) short_sum -= 64'(history[(wptr + WINDOW - ns) % WINDOW]);
    if (seen >= nl) long_sum -= 64'(history[(wptr + WINDOW - nl) % WINDOW]);
    history[wptr] = it.sample;
    wptr = (wptr + 1) % WINDOW;
    if (seen < nl) seen++;

    r = '0;
    r.trace_end = it.last_sample;
    if (seen >= nl) begin
      r.ratio_valid = 1'b1;
      if (long_sum == 0) begin
        r.zero_long_sum = 1'b1;
      end else begin
        num = (128'(short_sum) * 128'(nl)) << stalta_pkg::FRAC_BITS;
        den = 128'(long_sum) * 128'(ns);
        quo = num / den;
        r.ratio = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      end
    end
    expected_ratios.push_back(r);
    if (it.last_sample) clear_trace();
  endfunction

  function void check_result(stalta_pkg::result_t got);
    stalta_pkg::result_t want;
    if (expected_ratios.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result with nothing outstanding: ratio %h valid %b zero %b end %b",
                 $time, got.ratio, got.ratio_valid, got.zero_long_sum, got.trace_end);
      return;
    end
    want = expected_ratios.pop_front();
    if (got.ratio !== want.ratio || got.ratio_valid !== want.ratio_valid ||
        got.zero_long_sum !== want.zero_long_sum || got.trace_end !== want.trace_end) begin
      failures++;
      if (failures <= 10)
        $display("%0t: expected ratio %h valid %b zero %b end %b, got ratio %h valid %b zero %b end %b",
                 $time, want.ratio, want.ratio_valid, want.zero_long_sum, want.trace_end,
                 got.ratio, got.ratio_valid, got.zero_long_sum, got.trace_end);
    end
  endfunction

  function int pending();
    return expected_ratios.size();
  endfunction
endclass

module overlapping_sta_lta_ratio_test;
  import stalta_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 50;
  localparam int EXTREME_TRACE = 40;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_SPARSE, MIX_EXTREME} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_STA_LENGTH;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  ratio_scoreboard sb = new();

  overlapping_sta_lta_ratio dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: checks each result transaction and decides the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("overlapping_sta_lta_ratio_test failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_sample(input mix_t mix);
    case (mix)
      MIX_FULL: return $urandom();
      MIX_SMALL: return $urandom_range(255);
      MIX_SPARSE: return ($urandom_range(11) == 0) ? $urandom() : 32'd0;
      default: begin
        case ($urandom_range(2))
          0: return 32'd0;
          1: return 32'hFFFF_FFFF;
          default: return 32'd1 << $urandom_range(31);
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] value, input logic last);
    item_t next_item;
    next_item.sample = value;
    next_item.last_sample = last;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= next_item;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.take_sample(next_item);
  endtask

  task automatic stop_items();
    item_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Registers change only once every owed result has been taken.
  task automatic configure(input logic [STA_W-1:0] sta, input logic [LTA_W-1:0] lta);
    logic [31:0] noise;
    while (sb.pending() != 0) @(posedge clk);
    noise = $urandom();
    write_reg(CFG_STA_LENGTH, {noise[31:STA_W], sta});
    write_reg(CFG_LTA_LENGTH, {noise[31:LTA_W], lta});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [STA_W-1:0] sta, input logic [LTA_W-1:0] lta,
                           input int n_items, input int idle_pct, input int stall_prob,
                           input bit with_hold);
    int span;
    int left;
    int len;
    int shape;
    mix_t mix;
    configure(sta, lta);
    send_idle_pct = idle_pct;
    stall_pct = stall_prob;
    span = (lta < 2) ? 2 : ((lta > DEF_MAX_LONG_WINDOW) ? DEF_MAX_LONG_WINDOW : int'(lta));
    if (with_hold) holds_asked++;
    left = n_items;
    while (left > 0) begin
      // Mostly traces long enough to reach a valid ratio; some end early or run on.
      shape = $urandom_range(9);
      len = (shape < 7) ? span + $urandom_range(2 * span) : $urandom_range(1, span);
      if (len > left) len = left;
      mix = mix_t'($urandom_range(3));
      for (int i = 0; i < len; i++)
        send_sample(pick_sample(mix), (i == len - 1) && shape != 9);
      left -= len;
    end
    stop_items();
  endtask

  initial begin
    logic [STA_W-1:0] sta_pick;
    logic [LTA_W-1:0] lta_pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset lengths: nothing becomes valid in a short trace.
    send_sample(32'd5, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    stop_items();

    // Both lengths below range clamp to a short window of one and a long window of two.
    configure(12'd0, 13'd1);
    send_sample(32'd0, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd0, 1'b1);
    stop_items();

    // A register write in the middle of a trace starts a new one.
    configure(12'd2, 13'd3);
    send_sample(32'd9, 1'b0);
    stop_items();
    configure(12'd2, 13'd3);
    send_sample(32'd1, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd3, 1'b1);
    stop_items();

    // Short length above the long length is clamped to it.
    configure(12'd4095, 13'd3);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd0, 1'b1);
    stop_items();

    run_phase(12'd1, 13'd2, 225, 0, 0, 1'b0);
    run_phase(12'd3, 13'd16, 225, 67, 0, 1'b0);
    lta_pick = LTA_W'($urandom_range(2, 64));
    sta_pick = STA_W'($urandom_range(1, lta_pick - 1));
    run_phase(sta_pick, lta_pick, 225, 0, 67, 1'b1);
    run_phase(12'd0, 13'd0, 225, 27, 27, 1'b0);
    run_phase(12'd4095, 13'd37, 225, 0, 0, 1'b0);
    sta_pick = STA_W'($urandom_range(199));
    lta_pick = LTA_W'($urandom_range(200));
    run_phase(sta_pick, lta_pick, 225, 67, 0, 1'b0);
    run_phase(12'd10, 13'd11, 225, 0, 67, 1'b0);
    sta_pick = STA_W'($urandom_range(4095));
    lta_pick = LTA_W'($urandom_range(100));
    run_phase(sta_pick, lta_pick, 225, 27, 27, 1'b0);

    // Largest windows: the long length clamps to the history depth.
    configure(12'd4095, 13'd8191);
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < EXTREME_TRACE; i++)
      send_sample(pick_sample(mix_t'($urandom_range(3))), i == EXTREME_TRACE - 1);
    for (int i = 0; i < 5; i++)
      send_sample($urandom(), i == 4);
    stop_items();

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("overlapping_sta_lta_ratio_test passed");
    else
      $display("overlapping_sta_lta_ratio_test failed");
    $finish;
  end
endmodule
